// ===== hw/rtl/metv_pkg.sv =====
// ============================================================================
// metv_pkg
// Shared widths, constants and controller/datapath interface types for the
// encoder turn and velocity unit.
// ============================================================================
package metv_pkg;

    localparam int ANGLE_W   = 12;
    localparam int TURN_W    = 32;
    localparam int TOTAL_W   = 44;
    localparam int TIME_W    = 32;
    localparam int VEL_W     = 32;
    localparam int DIVIN_W   = 16;
    localparam int MAG_W     = 44;
    localparam int HALF_W    = 22;
    localparam int SCALE_W   = 20;
    localparam int PP_W      = HALF_W + SCALE_W;
    localparam int PROD_W    = 64;
    localparam int QUO_W     = 31;
    localparam int DCNT_W    = 5;

    localparam logic [SCALE_W-1:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [ANGLE_W-1:0] WRAP_RESET   = 12'd3276;
    localparam logic [DIVIN_W-1:0] DEFINT_RESET = 16'd1000;

    localparam logic [DCNT_W-1:0]  DIV_LAST_STEP = 5'(QUO_W - 1);

    localparam logic [VEL_W-1:0]   VEL_POS_MAX = 32'h7FFF_FFFF;
    localparam logic [VEL_W-1:0]   VEL_NEG_MIN = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic CFG_WRAP_THRESHOLD   = 1'b0;
    localparam logic CFG_DEFAULT_INTERVAL = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic prep;
        logic mul_lo;
        logic mul_hi;
        logic sum;
        logic div_step;
        logic load_out;
    } metv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic vel_go;
        logic sat;
        logic div_last;
        logic out_free;
    } metv_stat_t;

endpackage

// ===== hw/rtl/metv_ctrl.sv =====
// ============================================================================
// metv_ctrl
// Sequencer for one word: state update, velocity multiply, divide and the
// hand-off to the output register.
// ============================================================================
module metv_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  metv_pkg::metv_stat_t stat,
    output metv_pkg::metv_cmd_t  cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_PREP   = 7'b0000010,
        ST_MUL_LO = 7'b0000100,
        ST_MUL_HI = 7'b0001000,
        ST_SUM    = 7'b0010000,
        ST_DIV    = 7'b0100000,
        ST_DONE   = 7'b1000000
    } metv_state_t;

    metv_state_t state_reg;
    metv_state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.vel_go ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP:   state_next = ST_MUL_LO;
            ST_MUL_LO: state_next = ST_MUL_HI;
            ST_MUL_HI: state_next = ST_SUM;
            ST_SUM:    state_next = stat.sat ? ST_DONE : ST_DIV;
            ST_DIV: begin
                if (stat.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.prep     = (state_reg == ST_PREP);
    assign cmd.mul_lo   = (state_reg == ST_MUL_LO);
    assign cmd.mul_hi   = (state_reg == ST_MUL_HI);
    assign cmd.sum      = (state_reg == ST_SUM);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.load_out = (state_reg == ST_DONE) && stat.out_free;

    // A saturated quotient skips the divider entirely.
    a_sat_skips_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sum && stat.sat |=> !cmd.div_step)
        else $error("divider started after a saturated product");

    // No new word is taken until the present one has reached the output.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !s_tready)
        else $error("input accepted twice without finishing a word");

endmodule

// ===== hw/rtl/metv_dp.sv =====
// ============================================================================
// metv_dp
// Tracker state, configuration, velocity multiply, radix-2 restoring divider
// and the output register.
// ============================================================================
module metv_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  metv_pkg::metv_cmd_t                   cmd,
    output metv_pkg::metv_stat_t                  stat,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_addr,
    input  logic [metv_pkg::DIVIN_W-1:0]          cfg_wr_data,
    input  logic                                  in_op,
    input  logic [7:0]                            in_angle_high,
    input  logic [7:0]                            in_angle_low,
    input  logic [metv_pkg::TIME_W-1:0]           in_time_us,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [metv_pkg::ANGLE_W-1:0]          out_mech_angle,
    output logic [metv_pkg::TURN_W-1:0]           out_turns,
    output logic [metv_pkg::TOTAL_W-1:0]          out_total_angle,
    output logic [metv_pkg::VEL_W-1:0]            out_velocity,
    output logic                                  out_velocity_valid
);

    localparam int AW  = metv_pkg::ANGLE_W;
    localparam int TW  = metv_pkg::TURN_W;
    localparam int MW  = metv_pkg::MAG_W;
    localparam int HW  = metv_pkg::HALF_W;
    localparam int PW  = metv_pkg::PP_W;
    localparam int QW  = metv_pkg::QUO_W;
    localparam int DW  = metv_pkg::TIME_W;
    localparam int XW  = MW + 1;

    // Configuration.
    logic [AW-1:0]                  wrap_reg;
    logic [metv_pkg::DIVIN_W-1:0]   defint_reg;

    // Tracker state.
    logic                           primed_reg;
    logic [AW-1:0]                  angle_now_reg;
    logic [AW-1:0]                  angle_snap_reg;
    logic [TW-1:0]                  turn_count_reg;
    logic [TW-1:0]                  turn_snap_reg;
    logic [DW-1:0]                  time_now_reg;
    logic [DW-1:0]                  time_snap_reg;

    // Velocity working registers.
    logic                           vel_req_reg;
    logic                           neg_reg;
    logic                           sat_reg;
    logic [MW-1:0]                  mag_reg;
    logic [DW-1:0]                  divisor_reg;
    logic [PW-1:0]                  pp_lo_reg;
    logic [PW-1:0]                  pp_hi_reg;
    logic [DW-1:0]                  rem_reg;
    logic [QW-1:0]                  quo_reg;
    logic [metv_pkg::DCNT_W-1:0]    cnt_reg;

    logic                           out_valid_reg;

    // Turn detection on the incoming angle.
    logic [AW-1:0]                  angle_in;
    logic [AW:0]                    diff;
    logic [AW:0]                    abs_diff;
    logic                           wrapped;
    logic [TW-1:0]                  turn_step;

    always_comb begin
        angle_in  = {in_angle_high[3:0], in_angle_low};
        diff      = {1'b0, angle_in} - {1'b0, angle_now_reg};
        abs_diff  = diff[AW] ? ((AW+1)'(0) - diff) : diff;
        wrapped   = abs_diff > {1'b0, wrap_reg};
        // A positive jump means the angle wrapped backward through zero.
        turn_step = diff[AW] ? TW'(1) : {TW{1'b1}};
    end

    // Snapshot differences, formed once per velocity word.
    logic [DW-1:0]                  dt;
    logic [TW-1:0]                  dturn;
    logic [AW:0]                    dangle;
    logic [XW-1:0]                  delta;
    logic [XW-1:0]                  mag_full;
    logic [DW-1:0]                  divisor;

    always_comb begin
        dt       = time_now_reg - time_snap_reg;
        dturn    = turn_count_reg - turn_snap_reg;
        dangle   = {1'b0, angle_now_reg} - {1'b0, angle_snap_reg};
        delta    = {dturn[TW-1], dturn, {AW{1'b0}}} + {{(XW-AW-1){dangle[AW]}}, dangle};
        mag_full = delta[XW-1] ? (XW'(0) - delta) : delta;
        if (dt != '0) begin
            divisor = dt;
        end else if (defint_reg != '0) begin
            divisor = DW'(defint_reg);
        end else begin
            divisor = DW'(1);
        end
    end

    // Partial products of the magnitude and one million.
    logic [PW-1:0]                  pp_lo;
    logic [PW-1:0]                  pp_hi;
    logic [metv_pkg::PROD_W-1:0]    prod;
    logic                           sat_now;

    always_comb begin
        pp_lo   = {{(PW-HW){1'b0}}, mag_reg[HW-1:0]}
                * {{(PW-metv_pkg::SCALE_W){1'b0}}, metv_pkg::USEC_PER_SEC};
        pp_hi   = {{(PW-HW){1'b0}}, mag_reg[MW-1:HW]}
                * {{(PW-metv_pkg::SCALE_W){1'b0}}, metv_pkg::USEC_PER_SEC};
        prod    = {{(metv_pkg::PROD_W-PW){1'b0}}, pp_lo_reg}
                + {pp_hi_reg, {HW{1'b0}}};
        // The quotient reaches 2^31 exactly when the top bits reach the divisor.
        sat_now = prod[metv_pkg::PROD_W-1:QW] >= {1'b0, divisor_reg};
    end

    // One restoring division step.
    logic [DW:0]                    trial;
    logic                           ge;
    logic [DW:0]                    trial_sub;

    always_comb begin
        trial     = {rem_reg, quo_reg[QW-1]};
        ge        = trial >= {1'b0, divisor_reg};
        trial_sub = trial - {1'b0, divisor_reg};
    end

    // Final velocity word.
    logic [metv_pkg::VEL_W-1:0]     quo_ext;
    logic [metv_pkg::VEL_W-1:0]     vel_value;

    always_comb begin
        quo_ext = {1'b0, quo_reg};
        if (!vel_req_reg) begin
            vel_value = '0;
        end else if (sat_reg) begin
            vel_value = neg_reg ? metv_pkg::VEL_NEG_MIN : metv_pkg::VEL_POS_MAX;
        end else begin
            vel_value = neg_reg ? (metv_pkg::VEL_W'(0) - quo_ext) : quo_ext;
        end
    end

    assign stat.vel_go   = in_op && primed_reg;
    assign stat.sat      = sat_now;
    assign stat.div_last = (cnt_reg == metv_pkg::DIV_LAST_STEP);
    assign stat.out_free = !out_valid_reg || m_tready;

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_reg       <= metv_pkg::WRAP_RESET;
            defint_reg     <= metv_pkg::DEFINT_RESET;
            primed_reg     <= 1'b0;
            angle_now_reg  <= '0;
            angle_snap_reg <= '0;
            turn_count_reg <= '0;
            turn_snap_reg  <= '0;
            time_now_reg   <= '0;
            time_snap_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    metv_pkg::CFG_WRAP_THRESHOLD:   wrap_reg   <= cfg_wr_data[AW-1:0];
                    metv_pkg::CFG_DEFAULT_INTERVAL: defint_reg <= cfg_wr_data;
                    default:                        wrap_reg   <= wrap_reg;
                endcase
            end
            if (cmd.accept) begin
                angle_now_reg <= angle_in;
                time_now_reg  <= in_time_us;
                if (!primed_reg) begin
                    primed_reg     <= 1'b1;
                    angle_snap_reg <= angle_in;
                    time_snap_reg  <= in_time_us;
                end else if (wrapped) begin
                    turn_count_reg <= turn_count_reg + turn_step;
                end
            end
            if (cmd.prep) begin
                angle_snap_reg <= angle_now_reg;
                turn_snap_reg  <= turn_count_reg;
                time_snap_reg  <= time_now_reg;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Velocity datapath and output payload.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            vel_req_reg <= in_op && primed_reg;
        end
        if (cmd.prep) begin
            neg_reg     <= delta[XW-1];
            mag_reg     <= mag_full[MW-1:0];
            divisor_reg <= divisor;
        end
        if (cmd.mul_lo) begin
            pp_lo_reg <= pp_lo;
        end
        if (cmd.mul_hi) begin
            pp_hi_reg <= pp_hi;
        end
        if (cmd.sum) begin
            sat_reg <= sat_now;
            rem_reg <= prod[metv_pkg::PROD_W-2:QW];
            quo_reg <= prod[QW-1:0];
            cnt_reg <= '0;
        end
        if (cmd.div_step) begin
            rem_reg <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
            quo_reg <= {quo_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg + metv_pkg::DCNT_W'(1);
        end
        if (cmd.load_out) begin
            out_mech_angle     <= angle_now_reg;
            out_turns          <= turn_count_reg;
            out_total_angle    <= {turn_count_reg, angle_now_reg};
            out_velocity       <= vel_value;
            out_velocity_valid <= vel_req_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    // The partial remainder always stays below the divisor.
    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (rem_reg < divisor_reg))
        else $error("divider remainder reached the divisor");

    // A result is only written into a free or draining output register.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("output register overwritten before it was taken");

endmodule

// ===== hw/rtl/magnetic_encoder_turn_and_velocity_unit.sv =====
// ============================================================================
// magnetic_encoder_turn_and_velocity_unit
// Multi-turn tracker with velocity for a 12-bit absolute angle sensor.
// ============================================================================
// Sequence: an update-only or first word goes from acceptance straight to the
// done state; a velocity word also passes prep, two partial products, the sum
// and, unless the product saturates, the 31-step radix-2 restoring divider.
// Throughput: one word at a time, the next taken once the result is registered.
// Reset: synchronous, active-low aresetn clears the turn state, the primed
// flag and the output valid, and restores both configuration registers.
// ============================================================================
module magnetic_encoder_turn_and_velocity_unit (
    input  logic         aclk,
    input  logic         aresetn,

    // Input word.
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: angle_high [7:0], angle_low [15:8], time_us [47:16]
    input  logic [47:0]  s_tdata,
    // tuser: operation [0]
    input  logic [0:0]   s_tuser,

    // Result word.
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: mech_angle [11:0], turns [43:12], total_angle [87:44],
    //        velocity [119:88]
    output logic [119:0] m_tdata,
    // tuser: velocity_valid [0]
    output logic [0:0]   m_tuser,

    // Configuration write port.
    input  logic         cfg_wr_en,
    input  logic         cfg_addr,
    input  logic [15:0]  cfg_wr_data
);

    metv_pkg::metv_cmd_t  cmd;
    metv_pkg::metv_stat_t stat;

    logic [metv_pkg::ANGLE_W-1:0] out_mech_angle;
    logic [metv_pkg::TURN_W-1:0]  out_turns;
    logic [metv_pkg::TOTAL_W-1:0] out_total_angle;
    logic [metv_pkg::VEL_W-1:0]   out_velocity;
    logic                         out_velocity_valid;

    // The controller walks each word through its steps and only releases a
    // finished result when the output register is free or being drained, so
    // the next word can be accepted while the previous result still waits.
    metv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the tracker state, forms the velocity as delta * 10^6
    // / dt (default interval if dt is 0) with saturation, owns the output register.
    metv_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .stat               (stat),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_addr           (cfg_addr),
        .cfg_wr_data        (cfg_wr_data),
        .in_op              (s_tuser[0]),
        .in_angle_high      (s_tdata[7:0]),
        .in_angle_low       (s_tdata[15:8]),
        .in_time_us         (s_tdata[47:16]),
        .m_tready           (m_tready),
        .m_tvalid           (m_tvalid),
        .out_mech_angle     (out_mech_angle),
        .out_turns          (out_turns),
        .out_total_angle    (out_total_angle),
        .out_velocity       (out_velocity),
        .out_velocity_valid (out_velocity_valid)
    );

    // Result fields are packed from the lowest bit up with no gaps.
    assign m_tdata = {out_velocity, out_total_angle, out_turns, out_mech_angle};
    assign m_tuser = out_velocity_valid;

endmodule
